/* design/gtg_pkg.sv */
// Package for the go-to-goal controller: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package gtg_pkg;
   localparam int AtanEntries = 24;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

   typedef enum logic [1:0] {
      MODE_POSE   = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_TICK   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_WORLD  = 2'd1;
   localparam logic [1:0] CSR_GAIN   = 2'd2;

   // One queued job for the back end: a target scaling or a control tick.
   typedef struct packed {
      logic               is_tick;
      logic signed [13:0] tx;
      logic signed [13:0] ty;
   } job_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0: atan_q30 = 30'd843314856;
         5'd1: atan_q30 = 30'd497837829;
         5'd2: atan_q30 = 30'd263043836;
         5'd3: atan_q30 = 30'd133525158;
         5'd4: atan_q30 = 30'd67021686;
         5'd5: atan_q30 = 30'd33543515;
         5'd6: atan_q30 = 30'd16775850;
         5'd7: atan_q30 = 30'd8388437;
         5'd8: atan_q30 = 30'd4194282;
         5'd9: atan_q30 = 30'd2097149;
         5'd10: atan_q30 = 30'd1048575;
         5'd11: atan_q30 = 30'd524287;
         5'd12: atan_q30 = 30'd262143;
         5'd13: atan_q30 = 30'd131071;
         5'd14: atan_q30 = 30'd65535;
         5'd15: atan_q30 = 30'd32767;
         5'd16: atan_q30 = 30'd16383;
         5'd17: atan_q30 = 30'd8191;
         5'd18: atan_q30 = 30'd4095;
         5'd19: atan_q30 = 30'd2047;
         5'd20: atan_q30 = 30'd1023;
         5'd21: atan_q30 = 30'd511;
         5'd22: atan_q30 = 30'd255;
         5'd23: atan_q30 = 30'd127;
         default: atan_q30 = 30'd0;
      endcase
   endfunction
endpackage

/* design/gtg_front.sv */
// Front end: accepts transactions, applies pose updates, queues target and tick jobs.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_front
   import gtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         mode,
   input  logic signed [15:0] pos_x,
   input  logic signed [15:0] pos_y,
   input  logic signed [15:0] heading,
   input  logic signed [13:0] target_x_px,
   input  logic signed [13:0] target_y_px,
   input  logic               job_full,
   output logic               job_push,
   output job_type            job,
   output logic signed [15:0] robot_x_ff,
   output logic signed [15:0] robot_y_ff,
   output logic signed [15:0] robot_heading_ff
);
   logic accept;
   assign full   = job_full;
   assign accept = push && !full;
   assign job_push = accept && (mode == MODE_TARGET || mode == MODE_TICK);
   assign job.is_tick = (mode == MODE_TICK);
   assign job.tx = target_x_px;
   assign job.ty = target_y_px;

   // Pose is applied at once; the queue is in order, so a later tick must not
   // see it early. Ordering is kept by stalling while jobs are pending (full).
   always_ff @(posedge clock) begin
      if (reset) begin
         robot_x_ff <= '0;
         robot_y_ff <= '0;
         robot_heading_ff <= '0;
      end else if (accept && mode == MODE_POSE) begin
         robot_x_ff <= pos_x;
         robot_y_ff <= pos_y;
         robot_heading_ff <= heading;
      end
   end
endmodule

/* design/gtg_queue.sv */
// Two-entry job queue between front and back end.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_queue
   import gtg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   output logic    full,
   output logic    busy,
   input  logic    pop,
   output logic    valid,
   output job_type dout
);
   job_type mem [2];
   logic [1:0] count_ff, count_in;
   logic       wptr_ff, rptr_ff;
   logic       do_push, do_pop;
   logic       busy_hold;

   assign valid   = (count_ff != 2'd0);
   assign do_pop  = pop && valid;
   assign do_push = push && !full;
   assign dout    = mem[rptr_ff];
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wptr_ff <= ~wptr_ff;
         if (do_pop) rptr_ff <= ~rptr_ff;
      end
      if (do_push) mem[wptr_ff] <= din;
   end
   assign full = (count_ff == 2'd2) || busy_hold;
   assign busy = valid;
   // Pose updates must not overtake queued jobs; hold the front end while any
   // job is queued or in progress is decided at the top (busy).
   assign busy_hold = 1'b0;
endmodule

/* design/gtg_back.sv */
// Back end: serial divider for target scaling, iterated CORDIC and output stage.
// Depends on gtg_pkg.
`timescale 1ns / 1ps
module gtg_back
   import gtg_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_pop,
   output logic               idle,
   input  logic [12:0]        window_height,
   input  logic [15:0]        world_height,
   input  logic [15:0]        gain,
   input  logic signed [15:0] robot_x,
   input  logic signed [15:0] robot_y,
   input  logic signed [15:0] robot_heading,
   output logic               out_valid,
   input  logic               out_pop,
   output logic [15:0]        out_speed,
   output logic signed [15:0] out_rate
);
   localparam int Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

   typedef enum logic [3:0] {
      S_IDLE, S_DMUL, S_DIV, S_DNEXT, S_CPRE, S_CITER, S_LMUL, S_SMUL, S_OUT
   } state_type;

   state_type state_ff;
   logic               axis_ff;
   logic signed [13:0] tx_ff;
   logic signed [13:0] ty_ff;
   logic               neg_ff;
   logic [29:0]        num_ff;
   logic [29:0]        quo_ff;
   logic [13:0]        rem_ff;
   logic [4:0]         cnt_ff;
   logic signed [15:0] goal_x_ff, goal_y_ff;
   logic signed [34:0] x_ff, y_ff;
   logic signed [35:0] z_ff;
   logic [33:0]        len_ff;
   logic [15:0]        spd_ff;
   logic signed [15:0] rate_ff;
   logic               ovalid_ff;
   logic [49:0]        prod_ff;

   // Divider step.
   logic [14:0] rem_shift;
   logic        rem_ge;
   assign rem_shift = {rem_ff, num_ff[29]};
   assign rem_ge    = rem_shift >= {2'b0, window_height};

   // Absolute pixel value of the selected axis; S_DMUL multiplies it by world height and adds half the divisor.
   logic signed [13:0] px_sel;
   logic [13:0]        px_abs;
   assign px_sel = axis_ff ? ty_ff : tx_ff;
   assign px_abs = px_sel[13] ? 14'(-px_sel) : px_sel;

   // CORDIC step.
   logic signed [34:0] dx, dy;
   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;

   // Error vector.
   logic signed [16:0] ex, ey;
   assign ex = 17'(goal_x_ff) - 17'(robot_x);
   assign ey = 17'(goal_y_ff) - 17'(robot_y);

   logic signed [35:0] bsum;
   logic signed [17:0] bear;
   logic signed [18:0] rdiff;
   assign bsum  = z_ff + 36'sd131072;
   assign bear  = 18'(bsum >>> 18);
   assign rdiff = 19'(bear) - 19'(robot_heading);

   logic signed [30:0] qs;
   assign qs = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   assign job_pop   = (state_ff == S_IDLE) && job_valid && !ovalid_ff;
   assign idle      = (state_ff == S_IDLE) && !job_valid;
   assign out_valid = ovalid_ff;
   assign out_speed = spd_ff;
   assign out_rate  = rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
      end else begin
         if (out_pop && ovalid_ff) ovalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_pop) begin
                  if (job.is_tick) state_ff <= S_CPRE;
                  else if (window_height != 13'd0) begin
                     tx_ff   <= job.tx;
                     ty_ff   <= job.ty;
                     axis_ff <= 1'b0;
                     state_ff <= S_DMUL;
                  end
               end
            end
            S_DMUL: begin
               // 14x16 product plus half the divisor.
               num_ff <= 30'(px_abs * world_height) + 30'(window_height >> 1);
               neg_ff <= px_sel[13];
               rem_ff <= '0;
               cnt_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               num_ff <= {num_ff[28:0], 1'b0};
               quo_ff <= {quo_ff[28:0], rem_ge};
               rem_ff <= rem_ge ? 14'(rem_shift - {2'b0, window_height}) : rem_shift[13:0];
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd29) state_ff <= S_DNEXT;
            end
            S_DNEXT: begin
               if (!axis_ff) begin
                  goal_x_ff <= (qs > 31'sd32767) ? 16'sd32767 :
                               (qs < -31'sd32768) ? -16'sd32768 : 16'(qs);
                  axis_ff <= 1'b1;
                  state_ff <= S_DMUL;
               end else begin
                  goal_y_ff <= (qs > 31'sd32767) ? 16'sd32767 :
                               (qs < -31'sd32768) ? -16'sd32768 : 16'(qs);
                  state_ff <= S_IDLE;
               end
            end
            S_CPRE: begin
               cnt_ff <= '0;
               if (ex == 17'sd0 && ey == 17'sd0) begin
                  x_ff <= '0;
                  z_ff <= '0;
                  state_ff <= S_LMUL;
               end else if (ex < 0) begin
                  x_ff <= -(35'(ex) <<< 12);
                  y_ff <= -(35'(ey) <<< 12);
                  z_ff <= (ey >= 0) ? 36'(PI_Q30) : -36'(PI_Q30);
                  state_ff <= S_CITER;
               end else begin
                  x_ff <= 35'(ex) <<< 12;
                  y_ff <= 35'(ey) <<< 12;
                  z_ff <= '0;
                  state_ff <= S_CITER;
               end
            end
            S_CITER: begin
               if (y_ff >= 0) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + 36'(atan_q30(cnt_ff));
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - 36'(atan_q30(cnt_ff));
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(Steps - 1)) state_ff <= S_LMUL;
            end
            S_LMUL: begin
               // x stays below 2^31; one 32x32 multiply.
               len_ff <= 34'((64'(x_ff[31:0]) * 64'(INV_GAIN_Q32)) >> 32);
               state_ff <= S_SMUL;
            end
            S_SMUL: begin
               prod_ff <= 50'(len_ff) * 50'(gain) + 50'd134217728;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!ovalid_ff) begin
                  spd_ff <= (prod_ff[49:28] > 22'd65535) ? 16'hFFFF : prod_ff[43:28];
                  rate_ff <= (rdiff > 19'sd32767) ? 16'sd32767 :
                             (rdiff < -19'sd32768) ? -16'sd32768 : 16'(rdiff);
                  ovalid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !ovalid_ff) |=> ovalid_ff)
      else $error("result not raised");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CITER) |-> (cnt_ff < 5'(Steps)))
      else $error("cordic count overrun");
   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !ovalid_ff)
      else $error("job taken while result waits");
endmodule

/* design/go_to_goal_p_controller_top.sv */
// Top level of the go-to-goal proportional controller.
// Depends on gtg_pkg, gtg_front, gtg_queue and gtg_back.
//
//   channel   handshake        payload
//   req       push / full      mode, pos_x, pos_y, heading, target_x_px, target_y_px
//   rsp       empty / pop      linear_speed, angular_rate
//   csr       csr_we           csr_index, csr_wdata
//
// A pose transaction is applied directly to the pose registers. A target
// transaction runs two 30-step serial divisions; a control tick runs the
// iterated CORDIC unit. Synchronous reset clears the goal and pose
// to zero and the registers to their defaults. The front end stalls (full) while
// any job is queued or running, so pose updates stay in order with ticks; a
// waiting result holds the back end until popped.
`timescale 1ns / 1ps
module go_to_goal_p_controller_top
   import gtg_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   input  logic signed [13:0] req_target_x_px,
   input  logic signed [13:0] req_target_y_px,
   output logic               empty,
   input  logic               pop,
   output logic [15:0]        rsp_linear_speed,
   output logic signed [15:0] rsp_angular_rate,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   logic [12:0] window_height_ff;
   logic [15:0] world_height_ff, gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_height_ff <= 13'd500;
         world_height_ff  <= 16'd11355;
         gain_ff          <= 16'd6554;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW: window_height_ff <= csr_wdata[12:0];
            CSR_WORLD:  world_height_ff  <= csr_wdata;
            CSR_GAIN:   gain_ff          <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic    q_full, q_busy, q_valid, q_pop, q_push, back_idle, out_valid;
   job_type q_in, q_out;
   logic signed [15:0] rx, ry, rh;

   // The front end is held whenever any earlier job is still in progress.
   logic front_hold;
   assign front_hold = q_full || q_busy || !back_idle;

   gtg_front u_front (
      .clock, .reset, .push, .full,
      .mode(req_mode), .pos_x(req_pos_x), .pos_y(req_pos_y), .heading(req_heading),
      .target_x_px(req_target_x_px), .target_y_px(req_target_y_px),
      .job_full(front_hold), .job_push(q_push), .job(q_in),
      .robot_x_ff(rx), .robot_y_ff(ry), .robot_heading_ff(rh)
   );

   gtg_queue u_queue (
      .clock, .reset, .push(q_push), .din(q_in), .full(q_full), .busy(q_busy),
      .pop(q_pop), .valid(q_valid), .dout(q_out)
   );

   gtg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .job_valid(q_valid), .job(q_out), .job_pop(q_pop),
      .idle(back_idle), .window_height(window_height_ff),
      .world_height(world_height_ff), .gain(gain_ff),
      .robot_x(rx), .robot_y(ry), .robot_heading(rh),
      .out_valid, .out_pop(pop), .out_speed(rsp_linear_speed),
      .out_rate(rsp_angular_rate)
   );

   assign empty = !out_valid;
endmodule

/* verif/tb_go_to_goal_p_controller_top.sv */
// Self-checking testbench for the go-to-goal proportional controller top level.
// Depends on gtg_pkg and go_to_goal_p_controller_top; predicts every tick result.
`timescale 1ns / 1ps
module tb_go_to_goal_p_controller_top;
   import gtg_pkg::*;

   typedef struct {
      mode_type         mode;
      logic signed [15:0] px, py, hd;
      logic signed [13:0] tx, ty;
   } cmd_type;

   typedef struct {
      logic [15:0]        speed;
      logic signed [15:0] rate;
   } cmd_out_type;

   localparam int Steps = 16;
   localparam longint PiQ30 = 64'sd3373259426;
   localparam longint InvGainQ32 = 64'd2608131496;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               push = 1'b0;
   logic               full;
   logic [1:0]         req_mode = '0;
   logic signed [15:0] req_pos_x = '0, req_pos_y = '0, req_heading = '0;
   logic signed [13:0] req_target_x_px = '0, req_target_y_px = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic [15:0]        rsp_linear_speed;
   logic signed [15:0] rsp_angular_rate;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = CSR_WINDOW;
   logic [15:0]        csr_wdata = '0;

   go_to_goal_p_controller_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: registers and stored pose/goal.
   longint win_h = 500, world_h = 11355, spd_gain = 6554;
   longint goal_x = 0, goal_y = 0, rob_x = 0, rob_y = 0, rob_hd = 0;

   cmd_type     pending_cmds[$];
   cmd_out_type expected_cmds[$];
   int          errors = 0;
   int          ticks_seen = 0;
   int          items_sent = 0;

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint scale_pixels(longint px);
      longint num, half, q;
      num = px * world_h;
      half = win_h / 2;
      q = (num >= 0) ? (num + half) / win_h : -((-num + half) / win_h);
      return clamp16(q);
   endfunction

   function automatic cmd_out_type steer_toward_goal();
      cmd_out_type r;
      longint ex, ey, x, y, z, dx, dy, len, spd, brg;
      ex = goal_x - rob_x;
      ey = goal_y - rob_y;
      x = ex * 4096;
      y = ey * 4096;
      z = 0;
      len = 0;
      if (ex != 0 || ey != 0) begin
         if (x < 0) begin
            z = (ey >= 0) ? PiQ30 : -PiQ30;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < Steps && i < AtanEntries; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end else begin
               x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
         end
         len = longint'((64'(x) * 64'(InvGainQ32)) >> 32);
      end
      spd = longint'((64'(len) * 64'(spd_gain) + (64'd1 << 27)) >> 28);
      if (spd > 65535) spd = 65535;
      brg = (z + (64'sd1 << 17)) >>> 18;
      r.speed = 16'(spd);
      r.rate = 16'(clamp16(brg - rob_hd));
      return r;
   endfunction

   // Applies one accepted transaction to the predictor state.
   task automatic predict_cmd(input cmd_type c);
      case (c.mode)
         MODE_POSE: begin
            rob_x = c.px; rob_y = c.py; rob_hd = c.hd;
         end
         MODE_TARGET: begin
            if (win_h != 0) begin
               goal_x = scale_pixels(c.tx);
               goal_y = scale_pixels(c.ty);
            end
         end
         MODE_TICK: expected_cmds.push_back(steer_toward_goal());
         default: ;
      endcase
   endtask

   // Driver: bursts of back-to-back requests separated by random gaps. An
   // item counts as accepted at an edge where push is high and full is low.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_cmd(pending_cmds.pop_front());
            items_sent++;
         end
         if ((push && !full) || !push) begin
            if (pending_cmds.size() != 0 && gap_left == 0) begin
               push <= 1'b1;
               req_mode <= pending_cmds[0].mode;
               req_pos_x <= pending_cmds[0].px;
               req_pos_y <= pending_cmds[0].py;
               req_heading <= pending_cmds[0].hd;
               req_target_x_px <= pending_cmds[0].tx;
               req_target_y_px <= pending_cmds[0].ty;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
               end
               burst_left--;
               if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                                 $urandom_range(1, 40);
            end else begin
               push <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // Monitor with its own stall pattern on pop; checks each popped transaction.
   int stall_phase = 0;
   always @(posedge clock) begin
      cmd_out_type e;
      if (!reset) begin
         if (pop && !empty) begin
            ticks_seen++;
            if (expected_cmds.size() == 0) begin
               $error("unexpected result: linear_speed=%0d angular_rate=%0d",
                      rsp_linear_speed, rsp_angular_rate);
               errors++;
            end else begin
               e = expected_cmds.pop_front();
               if (rsp_linear_speed !== e.speed) begin
                  $error("linear_speed expected %0d got %0d", e.speed, rsp_linear_speed);
                  errors++;
               end
               if (rsp_angular_rate !== e.rate) begin
                  $error("angular_rate expected %0d got %0d", e.rate, rsp_angular_rate);
                  errors++;
               end
            end
         end
         stall_phase = (stall_phase + 1) % 64;
         // Free-flowing for part of the pattern, random stalls elsewhere.
         pop <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   function automatic cmd_type make_cmd(mode_type m, int px, int py, int hd, int tx, int ty);
      cmd_type c;
      c.mode = m; c.px = 16'(px); c.py = 16'(py); c.hd = 16'(hd);
      c.tx = 14'(tx); c.ty = 14'(ty);
      return c;
   endfunction

   function automatic cmd_type random_cmd();
      int r;
      mode_type m;
      r = $urandom_range(0, 19);
      m = (r < 6) ? MODE_POSE : (r < 11) ? MODE_TARGET : (r < 19) ? MODE_TICK : MODE_UNUSED;
      return make_cmd(m, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Waits until all queued transactions are accepted and all results seen,
   // then lets the block finish any target scaling still in flight.
   task automatic drain();
      while (pending_cmds.size() != 0 || push || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // One write per call; the enable drops for a cycle before the next write.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW: win_h = val & 16'h1FFF;
         CSR_WORLD:  world_h = val;
         CSR_GAIN:   spd_gain = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero error at reset, extremes, pose/target edges, unused mode.
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_POSE, 0, 0, -32768, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_POSE, -32768, -32768, 32767, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_TARGET, 0, 0, 0, 8191, 8191));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_POSE, 32767, 32767, -32768, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_TARGET, 0, 0, 0, -8192, -8192));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_POSE, 100, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_TARGET, 0, 0, 0, 0, 1));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_TARGET, 0, 0, 0, -1, 0));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(MODE_UNUSED, -1, -1, -1, -1, -1));
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 0, 0));
      drain();

      // Phases with different register settings, extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_WINDOW, 1); write_reg(CSR_WORLD, 65535);
               write_reg(CSR_GAIN, 65535); end
            1: begin write_reg(CSR_WINDOW, 0); write_reg(CSR_WORLD, 0);
               write_reg(CSR_GAIN, 0); end
            2: begin write_reg(CSR_WINDOW, 8191); write_reg(CSR_WORLD, 1);
               write_reg(CSR_GAIN, 1); end
            3: begin write_reg(CSR_WINDOW, 500); write_reg(CSR_WORLD, 11355);
               write_reg(CSR_GAIN, 6554); end
            default: begin write_reg(CSR_WINDOW, $urandom_range(1, 8191));
               write_reg(CSR_WORLD, $urandom); write_reg(CSR_GAIN, $urandom); end
         endcase
         for (int i = 0; i < 150; i++) pending_cmds.push_back(random_cmd());
         drain();
      end

      $display("Covered %0d transactions and %0d checked control ticks",
               items_sent, ticks_seen);
      $display("over 7 register settings.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* go_to_goal_p_controller_top.f */
design/gtg_pkg.sv
design/gtg_front.sv
design/gtg_queue.sv
design/gtg_back.sv
design/go_to_goal_p_controller_top.sv
verif/tb_go_to_goal_p_controller_top.sv
